// ===== rtl/line_line_intersection_top_defines.svh =====
// assertion macros shared by the line intersection checks
`ifndef LINE_LINE_INTERSECTION_TOP_DEFINES_SVH
`define LINE_LINE_INTERSECTION_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LLI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_line_intersection_top check failed");

// consequent must hold in the cycle after the antecedent
`define LLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_line_intersection_top check failed");

`endif

// ===== rtl/lli_pkg.sv =====
// package: payload types and fixed widths for the line intersection block
`timescale 1ns / 1ps

package lli_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int OUT_W       = 32;

  // largest positive and most negative result values
  localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_start_x;
    logic signed [COORD_WIDTH-1:0] first_start_y;
    logic signed [COORD_WIDTH-1:0] first_end_x;
    logic signed [COORD_WIDTH-1:0] first_end_y;
    logic signed [COORD_WIDTH-1:0] second_start_x;
    logic signed [COORD_WIDTH-1:0] second_start_y;
    logic signed [COORD_WIDTH-1:0] second_end_x;
    logic signed [COORD_WIDTH-1:0] second_end_y;
  } line_pair_t;

  typedef struct packed {
    logic                    found;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
  } point_t;

endpackage

// ===== rtl/line_line_intersection_top.sv =====
// top level: pipelined two-line intersection in exact fixed point
// throughput: one line pair per cycle while the output buffer is not full; the quotient
//   comes from a 32-stage restoring divider, one quotient bit per stage for x and y against
//   their common divisor
// reset: clears the stage valid bits and the two-entry output buffer; payload is not reset
`timescale 1ns / 1ps

module line_line_intersection_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                line_valid,
  output logic                line_ready,
  input  lli_pkg::line_pair_t line_pair,
  output logic                point_valid,
  input  logic                point_ready,
  output lli_pkg::point_t     point
);
  import lli_pkg::*;

  localparam int W        = COORD_WIDTH;
  localparam int DW       = W + 1;               // coordinate differences
  localparam int PW       = 2 * DW;              // difference products
  localparam int CW       = PW + 1;              // cross product and numerator
  localparam int LOW_W    = CW / 2;              // unsigned low half of a split operand
  localparam int HIGH_W   = CW - LOW_W;          // signed high half
  localparam int AX_LO_W  = W + LOW_W + 1;
  localparam int AX_HI_W  = W + HIGH_W;
  localparam int DX_LO_W  = DW + LOW_W + 1;
  localparam int DX_HI_W  = DW + HIGH_W;
  localparam int LO_SUM_W = DX_LO_W + 1;
  localparam int HI_SUM_W = DX_HI_W + 1;
  localparam int NW       = DW + CW + 1;         // point numerator
  localparam int NPW      = (NW > OUT_W) ? NW : OUT_W + 1;
  localparam int DDW      = CW + FRAC_BITS;      // divisor with fraction scaling
  localparam int CMPW     = NPW + DDW;
  localparam int QW       = OUT_W;
  localparam int NSTAGE   = QW + 11;

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;

  typedef struct packed {
    logic found;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } side_t;

  // pipeline control
  logic              en;
  logic [NSTAGE-1:0] vld;
  logic [1:0]        cnt;
  logic [1:0]        cnt_next;
  logic              push;
  logic              pop;
  point_t            buf0;
  point_t            buf1;
  point_t            res;

  assign en         = (cnt != BUF_FULL);
  assign line_ready = en;
  assign point_valid = (cnt != BUF_EMPTY);
  assign point      = buf0;
  assign push       = en && vld[NSTAGE-1];
  assign pop        = point_valid && point_ready;

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], line_valid};
    end
  end

  // stage 1: input register
  line_pair_t s1_pair;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pair <= line_pair;
    end
  end

  // stage 2: direction vectors and offset between start points
  logic signed [DW-1:0] s2_d1x, s2_d1y, s2_d2x, s2_d2y, s2_wx, s2_wy;
  logic signed [W-1:0]  s2_ax, s2_ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d1x <= DW'(s1_pair.first_end_x) - DW'(s1_pair.first_start_x);
      s2_d1y <= DW'(s1_pair.first_end_y) - DW'(s1_pair.first_start_y);
      s2_d2x <= DW'(s1_pair.second_end_x) - DW'(s1_pair.second_start_x);
      s2_d2y <= DW'(s1_pair.second_end_y) - DW'(s1_pair.second_start_y);
      s2_wx  <= DW'(s1_pair.second_start_x) - DW'(s1_pair.first_start_x);
      s2_wy  <= DW'(s1_pair.second_start_y) - DW'(s1_pair.first_start_y);
      s2_ax  <= s1_pair.first_start_x;
      s2_ay  <= s1_pair.first_start_y;
    end
  end

  // stage 3: the four products of the two cross products
  logic signed [PW-1:0] s3_ca, s3_cb, s3_na, s3_nb;
  logic signed [DW-1:0] s3_d1x, s3_d1y;
  logic signed [W-1:0]  s3_ax, s3_ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ca  <= s2_d1x * s2_d2y;
      s3_cb  <= s2_d1y * s2_d2x;
      s3_na  <= s2_wx * s2_d2y;
      s3_nb  <= s2_wy * s2_d2x;
      s3_d1x <= s2_d1x;
      s3_d1y <= s2_d1y;
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
    end
  end

  // stage 4: cross product and parameter numerator
  logic signed [CW-1:0] s4_cr, s4_num;
  logic signed [DW-1:0] s4_d1x, s4_d1y;
  logic signed [W-1:0]  s4_ax, s4_ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_cr  <= CW'(s3_ca) - CW'(s3_cb);
      s4_num <= CW'(s3_na) - CW'(s3_nb);
      s4_d1x <= s3_d1x;
      s4_d1y <= s3_d1y;
      s4_ax  <= s3_ax;
      s4_ay  <= s3_ay;
    end
  end

  // stage 5: split products for o1*cross and d1*num, divisor magnitude
  logic signed [LOW_W:0]    cr_lo, num_lo;
  logic signed [HIGH_W-1:0] cr_hi, num_hi;
  logic [CW-1:0]            cr_bits;

  assign cr_bits = s4_cr;
  assign cr_lo   = $signed({1'b0, cr_bits[LOW_W-1:0]});
  assign cr_hi   = $signed(cr_bits[CW-1:LOW_W]);
  assign num_lo  = $signed({1'b0, s4_num[LOW_W-1:0]});
  assign num_hi  = s4_num[CW-1:LOW_W];

  logic signed [AX_LO_W-1:0] s5_ax_lo, s5_ay_lo;
  logic signed [AX_HI_W-1:0] s5_ax_hi, s5_ay_hi;
  logic signed [DX_LO_W-1:0] s5_dx_lo, s5_dy_lo;
  logic signed [DX_HI_W-1:0] s5_dx_hi, s5_dy_hi;
  logic                      s5_found;
  logic                      s5_cr_neg;
  logic [CW-1:0]             s5_d_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ax_lo  <= s4_ax * cr_lo;
      s5_ax_hi  <= s4_ax * cr_hi;
      s5_ay_lo  <= s4_ay * cr_lo;
      s5_ay_hi  <= s4_ay * cr_hi;
      s5_dx_lo  <= s4_d1x * num_lo;
      s5_dx_hi  <= s4_d1x * num_hi;
      s5_dy_lo  <= s4_d1y * num_lo;
      s5_dy_hi  <= s4_d1y * num_hi;
      s5_found  <= (cr_bits != '0);
      s5_cr_neg <= cr_bits[CW-1];
      s5_d_mag  <= cr_bits[CW-1] ? (~cr_bits + CW'(1)) : cr_bits;
    end
  end

  // stage 6: add high halves and low halves separately
  logic signed [HI_SUM_W-1:0] s6_hi_x, s6_hi_y;
  logic signed [LO_SUM_W-1:0] s6_lo_x, s6_lo_y;
  logic                       s6_found;
  logic                       s6_cr_neg;
  logic [CW-1:0]              s6_d_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_hi_x   <= HI_SUM_W'(s5_ax_hi) + HI_SUM_W'(s5_dx_hi);
      s6_hi_y   <= HI_SUM_W'(s5_ay_hi) + HI_SUM_W'(s5_dy_hi);
      s6_lo_x   <= LO_SUM_W'(s5_ax_lo) + LO_SUM_W'(s5_dx_lo);
      s6_lo_y   <= LO_SUM_W'(s5_ay_lo) + LO_SUM_W'(s5_dy_lo);
      s6_found  <= s5_found;
      s6_cr_neg <= s5_cr_neg;
      s6_d_mag  <= s5_d_mag;
    end
  end

  // stage 7: full point numerators o1*cross + d1*num
  logic signed [NW-1:0] s7_nx, s7_ny;
  logic                 s7_found;
  logic                 s7_cr_neg;
  logic [CW-1:0]        s7_d_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_nx     <= $signed({s6_hi_x, {LOW_W{1'b0}}}) + NW'(s6_lo_x);
      s7_ny     <= $signed({s6_hi_y, {LOW_W{1'b0}}}) + NW'(s6_lo_y);
      s7_found  <= s6_found;
      s7_cr_neg <= s6_cr_neg;
      s7_d_mag  <= s6_d_mag;
    end
  end

  // stage 8: numerator magnitudes and result signs
  logic [NW-1:0] nx_bits, ny_bits;
  logic [NW-1:0] s8_nx_mag, s8_ny_mag;
  logic          s8_neg_x, s8_neg_y;
  logic          s8_found;
  logic [CW-1:0] s8_d_mag;

  assign nx_bits = s7_nx;
  assign ny_bits = s7_ny;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_nx_mag <= nx_bits[NW-1] ? (~nx_bits + NW'(1)) : nx_bits;
      s8_ny_mag <= ny_bits[NW-1] ? (~ny_bits + NW'(1)) : ny_bits;
      s8_neg_x  <= nx_bits[NW-1] ^ s7_cr_neg;
      s8_neg_y  <= ny_bits[NW-1] ^ s7_cr_neg;
      s8_found  <= s7_found;
      s8_d_mag  <= s7_d_mag;
    end
  end

  // stage 9: overflow test and divider load
  logic [DDW-1:0] r_x  [0:QW];
  logic [DDW-1:0] r_y  [0:QW];
  logic [QW-1:0]  qn_x [0:QW];
  logic [QW-1:0]  qn_y [0:QW];
  logic [DDW-1:0] dd   [0:QW];
  side_t          side [0:QW];

  logic [NPW-1:0]  nx_ext, ny_ext;
  logic [CMPW-1:0] top_x_cmp, top_y_cmp, dd_cmp;
  logic [DDW-1:0]  dd_init;

  assign nx_ext    = NPW'(s8_nx_mag);
  assign ny_ext    = NPW'(s8_ny_mag);
  assign top_x_cmp = CMPW'(nx_ext[NPW-1:QW]);
  assign top_y_cmp = CMPW'(ny_ext[NPW-1:QW]);
  assign dd_init   = DDW'(s8_d_mag) << FRAC_BITS;
  assign dd_cmp    = CMPW'(dd_init);

  always_ff @(posedge clk) begin
    if (en) begin
      r_x[0]        <= top_x_cmp[DDW-1:0];
      r_y[0]        <= top_y_cmp[DDW-1:0];
      qn_x[0]       <= nx_ext[QW-1:0];
      qn_y[0]       <= ny_ext[QW-1:0];
      dd[0]         <= dd_init;
      side[0].found <= s8_found;
      side[0].neg_x <= s8_neg_x;
      side[0].neg_y <= s8_neg_y;
      side[0].ovf_x <= (top_x_cmp >= dd_cmp);
      side[0].ovf_y <= (top_y_cmp >= dd_cmp);
    end
  end

  // divider: one restoring step per stage, numerator bits shift into the remainder, quotient bits shift in behind them
  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_div
      logic [DDW:0] tx, ty, dx, dy, dd_ext;
      logic         ge_x, ge_y;

      assign dd_ext = {1'b0, dd[k]};
      assign tx     = {r_x[k], qn_x[k][QW-1]};
      assign ty     = {r_y[k], qn_y[k][QW-1]};
      assign dx     = tx - dd_ext;
      assign dy     = ty - dd_ext;
      assign ge_x   = (tx >= dd_ext);
      assign ge_y   = (ty >= dd_ext);

      always_ff @(posedge clk) begin
        if (en) begin
          r_x[k+1]  <= ge_x ? dx[DDW-1:0] : tx[DDW-1:0];
          r_y[k+1]  <= ge_y ? dy[DDW-1:0] : ty[DDW-1:0];
          qn_x[k+1] <= {qn_x[k][QW-2:0], ge_x};
          qn_y[k+1] <= {qn_y[k][QW-2:0], ge_y};
          dd[k+1]   <= dd[k];
          side[k+1] <= side[k];
        end
      end
    end
  endgenerate

  // round to nearest, ties to even, on the magnitudes
  logic [DDW:0]   twice_rx, twice_ry, dd_last;
  logic           up_x, up_y;
  logic [OUT_W:0] rd_mx, rd_my;
  side_t          rd_side;

  assign twice_rx = {r_x[QW], 1'b0};
  assign twice_ry = {r_y[QW], 1'b0};
  assign dd_last  = {1'b0, dd[QW]};
  assign up_x = (twice_rx > dd_last) || ((twice_rx == dd_last) && qn_x[QW][0]);
  assign up_y = (twice_ry > dd_last) || ((twice_ry == dd_last) && qn_y[QW][0]);

  always_ff @(posedge clk) begin
    if (en) begin
      rd_mx   <= {1'b0, qn_x[QW]} + (OUT_W+1)'(up_x);
      rd_my   <= {1'b0, qn_y[QW]} + (OUT_W+1)'(up_y);
      rd_side <= side[QW];
    end
  end

  // apply sign and clamp to the signed 32-bit range
  function automatic logic [OUT_W-1:0] saturate(
    input logic [OUT_W:0] mag,
    input logic           neg,
    input logic           ovf
  );
    logic [OUT_W-1:0] r;
    if (neg) begin
      if (ovf || (mag > {1'b0, NEG_LIMIT})) r = NEG_LIMIT;
      else r = ~mag[OUT_W-1:0] + OUT_W'(1);
    end else begin
      if (ovf || (mag > {1'b0, POS_LIMIT})) r = POS_LIMIT;
      else r = mag[OUT_W-1:0];
    end
    return r;
  endfunction

  // final stage: parallel lines give zeros
  always_ff @(posedge clk) begin
    if (en) begin
      res.found   <= rd_side.found;
      res.cross_x <= rd_side.found ? saturate(rd_mx, rd_side.neg_x, rd_side.ovf_x) : '0;
      res.cross_y <= rd_side.found ? saturate(rd_my, rd_side.neg_y, rd_side.ovf_y) : '0;
    end
  end

  // two-entry output buffer, head entry drives the port
  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + 2'd1;
    else if (pop && !push) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= BUF_EMPTY;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (cnt == BUF_ONE)) buf0 <= res;
      else buf0 <= buf1;
      if (push && (cnt == BUF_FULL)) buf1 <= res;
    end else if (push) begin
      if (cnt == BUF_EMPTY) buf0 <= res;
      else buf1 <= res;
    end
  end

endmodule

// ===== rtl/lli_checker.sv =====
// checker: port-level properties of the line intersection block, bound to the top level
`timescale 1ns / 1ps
`include "line_line_intersection_top_defines.svh"

module lli_checker (
  input logic            clk,
  input logic            rst,
  input logic            line_valid,
  input logic            line_ready,
  input logic            point_valid,
  input logic            point_ready,
  input lli_pkg::point_t point
);

  // requests accepted and not yet delivered
  logic [5:0] pending;
  logic       zero_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 6'(line_valid && line_ready) - 6'(point_valid && point_ready);
    end
  end

  // both coordinates of the result are zero
  assign zero_point = (point.cross_x == 32'sd0) && (point.cross_y == 32'sd0);

  // a stalled result holds
  `LLI_ASSERT_NEXT(a_hold, clk, rst, point_valid && !point_ready, point_valid && $stable(point))
  // no result without an outstanding request
  `LLI_ASSERT_SAME(a_no_phantom, clk, rst, point_valid, pending != 6'd0)
  // input side only stalls while a result is waiting
  `LLI_ASSERT_SAME(a_ready_stall, clk, rst, !line_ready, point_valid)
  // parallel lines report a zero point
  `LLI_ASSERT_SAME(a_parallel_zero, clk, rst, point_valid && !point.found, zero_point)

endmodule

bind line_line_intersection_top lli_checker u_lli_checker (
  .clk         (clk),
  .rst         (rst),
  .line_valid  (line_valid),
  .line_ready  (line_ready),
  .point_valid (point_valid),
  .point_ready (point_ready),
  .point       (point)
);

// ===== sim/tb_line_line_intersection_top.sv =====
// testbench for the line intersection block: directed and random line pairs against a predictor
`timescale 1ns / 1ps

module tb_line_line_intersection_top;
  import lli_pkg::*;

  localparam int FRAC_BITS      = 8;
  localparam int RANDOM_ITEMS   = 850;
  localparam int HOLD_OFF_AT    = 200;
  localparam int HOLD_OFF_LEN   = 200;
  localparam int STEADY_FROM    = 350;
  localparam int STEADY_TO      = 450;
  localparam int DRAIN_AT       = 600;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  localparam int C_MAX = 8388607;
  localparam int C_MIN = -8388608;

  typedef logic signed [127:0] wide_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    line_pair_t pair;
    logic       typed;
    point_t     want;
  } probe_t;

  typedef enum int {
    SHAPE_ANY, SHAPE_SMALL, SHAPE_PARALLEL, SHAPE_NEAR, SHAPE_DEGENERATE,
    SHAPE_EXTREME, SHAPE_GRID
  } shape_t;

  logic       clk;
  logic       rst;
  logic       line_valid;
  logic       line_ready;
  line_pair_t line_pair;
  logic       point_valid;
  logic       point_ready;
  point_t     point;

  point_t pending_points[$];
  probe_t directed_rows[$];
  int     mismatch_count;
  bit     hold_off_req;
  bit     steady;

  line_line_intersection_top #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line_pair  (line_pair),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point      (point)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // nearest integer of numer / denom, ties to even, clamped to 32-bit signed
  function automatic logic signed [31:0] round_to_pixel(wide_t numer, wide_t denom);
    logic [127:0] mag_n;
    logic [127:0] mag_d;
    logic [127:0] quot;
    logic [127:0] rem;
    logic         neg;
    neg   = numer[127] ^ denom[127];
    mag_n = numer[127] ? -numer : numer;
    mag_d = denom[127] ? -denom : denom;
    quot  = mag_n / mag_d;
    rem   = mag_n % mag_d;
    if ((rem << 1) > mag_d || ((rem << 1) == mag_d && quot[0])) quot = quot + 1;
    if (neg) begin
      if (quot > 128'h8000_0000) return NEG_LIMIT;
      return -quot[31:0];
    end
    if (quot > 128'h7FFF_FFFF) return POS_LIMIT;
    return quot[31:0];
  endfunction

  // exact crossing point of two lines in whole pixels
  function automatic point_t predict_crossing(line_pair_t lp);
    wide_t  ax, ay, bx, by, cx, cy, ex, ey;
    wide_t  cr, num, den, nx, ny;
    point_t pt;
    ax = $signed(lp.first_start_x);
    ay = $signed(lp.first_start_y);
    bx = $signed(lp.first_end_x);
    by = $signed(lp.first_end_y);
    cx = $signed(lp.second_start_x);
    cy = $signed(lp.second_start_y);
    ex = $signed(lp.second_end_x);
    ey = $signed(lp.second_end_y);
    pt = '0;
    cr = (bx - ax) * (ey - cy) - (by - ay) * (ex - cx);
    if (cr == 0) return pt;
    num = (cx - ax) * (ey - cy) - (cy - ay) * (ex - cx);
    den = cr * (wide_t'(1) <<< FRAC_BITS);
    nx  = ax * cr + (bx - ax) * num;
    ny  = ay * cr + (by - ay) * num;
    pt.found   = 1'b1;
    pt.cross_x = round_to_pixel(nx, den);
    pt.cross_y = round_to_pixel(ny, den);
    return pt;
  endfunction

  // bits above the coordinate width are dropped
  function automatic line_pair_t make_pair(int ax, int ay, int bx, int by,
                                           int cx, int cy, int ex, int ey);
    line_pair_t lp;
    lp.first_start_x  = COORD_WIDTH'(ax);
    lp.first_start_y  = COORD_WIDTH'(ay);
    lp.first_end_x    = COORD_WIDTH'(bx);
    lp.first_end_y    = COORD_WIDTH'(by);
    lp.second_start_x = COORD_WIDTH'(cx);
    lp.second_start_y = COORD_WIDTH'(cy);
    lp.second_end_x   = COORD_WIDTH'(ex);
    lp.second_end_y   = COORD_WIDTH'(ey);
    return lp;
  endfunction

  function automatic probe_t probe_row(line_pair_t lp, bit typed = 1'b0, bit found = 1'b0,
                                       int px = 0, int py = 0);
    probe_t row;
    row.pair          = lp;
    row.typed         = typed;
    row.want.found    = found;
    row.want.cross_x  = px;
    row.want.cross_y  = py;
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(probe_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($urandom);
    endcase
  endfunction

  // random line pair, weighted toward the interesting geometries
  function automatic line_pair_t random_pair();
    shape_t     shape;
    int         ax, ay, bx, by, cx, cy, ex, ey, dx, dy, k;
    int         pick;
    line_pair_t lp;
    pick = $urandom_range(0, 11);
    case (pick)
      0, 1, 2: shape = SHAPE_ANY;
      3, 4:    shape = SHAPE_SMALL;
      5, 6:    shape = SHAPE_PARALLEL;
      7:       shape = SHAPE_NEAR;
      8:       shape = SHAPE_DEGENERATE;
      9:       shape = SHAPE_EXTREME;
      default: shape = SHAPE_GRID;
    endcase
    case (shape)
      SHAPE_ANY: begin
        lp = make_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
      end
      SHAPE_SMALL: begin
        lp = make_pair(spread(2048), spread(2048), spread(2048), spread(2048),
                       spread(2048), spread(2048), spread(2048), spread(2048));
      end
      SHAPE_PARALLEL: begin
        // second direction is a whole multiple of the first, sometimes on the same line
        ax = spread(1000000);
        ay = spread(1000000);
        dx = spread(1000);
        dy = spread(1000);
        k  = spread(3);
        if ($urandom_range(0, 3) == 0) begin
          cx = ax + spread(50) * dx;
          cy = ay + (cx - ax) / (dx == 0 ? 1 : dx) * dy;
          if (dx == 0) cy = ay + spread(50) * dy;
        end else begin
          cx = spread(1000000);
          cy = spread(1000000);
        end
        lp = make_pair(ax, ay, ax + dx, ay + dy, cx, cy, cx + k * dx, cy + k * dy);
      end
      SHAPE_NEAR: begin
        // almost parallel long lines meet far away and often clamp
        ax = spread(2000000);
        ay = spread(2000000);
        cx = spread(2000000);
        cy = spread(2000000);
        dx = spread(4000000);
        dy = spread(8);
        lp = make_pair(ax, ay, ax + dx, ay + dy,
                       cx, cy, cx + dx + spread(2), cy + dy + spread(2));
      end
      SHAPE_DEGENERATE: begin
        ax = $urandom;
        ay = $urandom;
        if ($urandom_range(0, 1) == 0)
          lp = make_pair(ax, ay, ax, ay, $urandom, $urandom, $urandom, $urandom);
        else
          lp = make_pair($urandom, $urandom, $urandom, $urandom, ax, ay, ax, ay);
      end
      SHAPE_EXTREME: begin
        lp = make_pair(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                       extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
      end
      default: begin
        // half-pixel grid gives many exact rounding ties
        lp = make_pair(spread(32) * 128, spread(32) * 128, spread(32) * 128, spread(32) * 128,
                       spread(32) * 128, spread(32) * 128, spread(32) * 128, spread(32) * 128);
      end
    endcase
    return lp;
  endfunction

  // gap length: none half the time, some short, a few long; always none while steady
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer(line_pair_t lp, point_t want);
    line_pair  <= lp;
    line_valid <= 1'b1;
    @(posedge clk);
    while (!line_ready) @(posedge clk);
    pending_points.insert(pending_points.size(), want);
  endtask

  task automatic pause();
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      line_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", field, $signed(want), $signed(got));
  endtask

  // directed table
  initial begin
    add_row(probe_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 0, 0));
    add_row(probe_row(make_pair(C_MAX, C_MAX, C_MAX, C_MAX,
                                C_MAX, C_MAX, C_MAX, C_MAX), 1'b1, 1'b0, 0, 0));
    add_row(probe_row(make_pair(C_MIN, C_MIN, C_MIN, C_MIN,
                                C_MIN, C_MIN, C_MIN, C_MIN), 1'b1, 1'b0, 0, 0));
    // diagonals meet at half a pixel, tie goes to zero
    add_row(probe_row(make_pair(0, 0, 256, 256, 0, 256, 256, 0),
                      1'b1, 1'b1, 0, 0));
    // x at 1.5, -1.5 and 2.5 pixels, ties to even
    add_row(probe_row(make_pair(0, 0, 1024, 0, 384, -256, 384, 256),
                      1'b1, 1'b1, 2, 0));
    add_row(probe_row(make_pair(0, 0, 1024, 0, -384, -256, -384, 256),
                      1'b1, 1'b1, -2, 0));
    add_row(probe_row(make_pair(0, 0, 1024, 0, 640, -256, 640, 256),
                      1'b1, 1'b1, 2, 0));
    // just under a half rounds down
    add_row(probe_row(make_pair(0, 0, 1024, 0, 383, -256, 383, 256),
                      1'b1, 1'b1, 1, 0));
    add_row(probe_row(make_pair(-512, -512, -256, -512, -384, 0, -384, -256),
                      1'b1, 1'b1, -2, -2));
    add_row(probe_row(make_pair(256, 512, 1280, 512, 768, 0, 768, 1024),
                      1'b1, 1'b1, 3, 2));
    // coincident, parallel and zero-length lines
    add_row(probe_row(make_pair(0, 0, 256, 256, 512, 512, 768, 768),
                      1'b1, 1'b0, 0, 0));
    add_row(probe_row(make_pair(0, 0, 256, 0, 0, 256, 512, 256),
                      1'b1, 1'b0, 0, 0));
    add_row(probe_row(make_pair(100, 100, 100, 100, 0, 0, 256, 256),
                      1'b1, 1'b0, 0, 0));
    add_row(probe_row(make_pair(0, 0, 256, 256, 5, 5, 5, 5),
                      1'b1, 1'b0, 0, 0));
    // shallow line against a horizontal one at the top and bottom edge: x clamps
    add_row(probe_row(make_pair(C_MIN, 0, C_MAX, 1, 0, C_MAX, 1, C_MAX),
                      1'b1, 1'b1, int'(POS_LIMIT), 32768));
    add_row(probe_row(make_pair(C_MIN, 0, C_MAX, 1, 0, C_MIN, 1, C_MIN),
                      1'b1, 1'b1, int'(NEG_LIMIT), -32768));
    // extremes mixed, checked by the predictor
    add_row(probe_row(make_pair(C_MAX, C_MIN, C_MIN, C_MAX,
                                C_MIN, C_MIN, C_MAX, C_MAX)));
    add_row(probe_row(make_pair(C_MIN, C_MAX, C_MAX, C_MIN,
                                C_MIN, C_MIN, C_MAX, C_MAX)));
    add_row(probe_row(make_pair(C_MAX, 0, 0, C_MAX, 0, 0, C_MAX, C_MAX)));
    add_row(probe_row(make_pair(-1, -1, 1, 1, 1, -1, -1, 1)));
    add_row(probe_row(make_pair(C_MAX, C_MAX, C_MIN, C_MIN,
                                C_MAX, C_MIN, C_MIN, C_MAX)));
  end

  // request side: reset, directed table, random pairs, drain
  initial begin
    rst            <= 1'b1;
    line_valid     <= 1'b0;
    line_pair      <= '0;
    mismatch_count = 0;
    hold_off_req   = 1'b0;
    steady         = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].pair,
            directed_rows[i].typed ? directed_rows[i].want
                                   : predict_crossing(directed_rows[i].pair));
      pause();
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      line_pair_t lp;
      if (n == HOLD_OFF_AT) hold_off_req = 1'b1;
      steady = (n >= STEADY_FROM && n < STEADY_TO);
      // let every outstanding point come back before going on
      if (n == DRAIN_AT) begin
        line_valid <= 1'b0;
        do @(posedge clk); while (pending_points.size() != 0);
      end
      lp = random_pair();
      offer(lp, predict_crossing(lp));
      pause();
    end
    line_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    int stall;
    point_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        point_ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          point_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        point_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // compare each point against the oldest expectation
  always @(posedge clk) begin
    point_t want;
    if (!rst && point_valid && point_ready) begin
      if (pending_points.size() == 0) begin
        flag_mismatch("unrequested point x", 32'd0, point.cross_x);
      end else begin
        want = pending_points.pop_front();
        if (point.found !== want.found)
          flag_mismatch("found", {31'd0, want.found}, {31'd0, point.found});
        if (point.cross_x !== want.cross_x) flag_mismatch("cross_x", want.cross_x, point.cross_x);
        if (point.cross_y !== want.cross_y) flag_mismatch("cross_y", want.cross_y, point.cross_y);
      end
    end
  end

  // watchdog on cycles with no request or point accepted
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (line_valid && line_ready) || (point_valid && point_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
